// ===== rtl/core/gniu_pkg.sv =====
// gniu_pkg: shared types, constants and helpers for the grid node index unit.
// No dependencies.
package gniu_pkg;

    localparam int unsigned MAX_SIDE_DEF = 1024;
    localparam int unsigned IDX_W  = 30;
    localparam int unsigned CRD_W  = 10;
    localparam int unsigned CFG_W  = 11;

    localparam logic [2:0] MODE_COMPOSE   = 3'd0;
    localparam logic [2:0] MODE_DECOMPOSE = 3'd1;
    localparam logic [2:0] MODE_FACE      = 3'd2;
    localparam logic [2:0] MODE_SIDE      = 3'd3;
    localparam logic [2:0] MODE_CORNER    = 3'd4;

    localparam logic [2:0] FACE_BOTTOM = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_LEFT   = 3'd3;
    localparam logic [2:0] FACE_BACK   = 3'd4;
    localparam logic [2:0] FACE_FRONT  = 3'd5;

    localparam logic [2:0] SIDE_BOTTOM = 3'd0;
    localparam logic [2:0] SIDE_RIGHT  = 3'd1;
    localparam logic [2:0] SIDE_TOP    = 3'd2;
    localparam logic [2:0] SIDE_LEFT   = 3'd3;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // Item context while dividing.
    typedef struct packed {
        logic [2:0]       mode;
        logic [2:0]       part;
        logic [IDX_W-1:0] pos;
        logic [CRD_W-1:0] ci;
        logic [CRD_W-1:0] rj;
        logic [CRD_W-1:0] lk;
        logic [CFG_W-1:0] sx;
        logic [CFG_W-1:0] sy;
        logic [CFG_W-1:0] sz;
    } t_ctx;

endpackage

// ===== rtl/core/gniu_div_cell.sv =====
// gniu_div_cell: one restoring-division step, registered, with stall.
// Depends on gniu_pkg.
module gniu_div_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [gniu_pkg::IDX_W-1:0] i_num,
    input  logic [gniu_pkg::IDX_W-1:0] i_quo,
    input  logic [gniu_pkg::CFG_W-1:0] i_dsr,
    output logic                     o_vld,
    output logic [gniu_pkg::IDX_W-1:0] o_num,
    output logic [gniu_pkg::IDX_W-1:0] o_quo,
    output logic [gniu_pkg::CFG_W-1:0] o_dsr
);
    import gniu_pkg::*;

    logic [IDX_W+CFG_W-1:0] w_sh;
    logic                   w_ge;
    logic [IDX_W-1:0]       n_num;
    logic [IDX_W-1:0]       n_quo;
    logic                   r_vld;
    logic [IDX_W-1:0]       r_num, r_quo;
    logic [CFG_W-1:0]       r_dsr;

    // Compare divisor << BIT against the partial remainder.
    assign w_sh = {{IDX_W{1'b0}}, i_dsr} << BIT;
    assign w_ge = ({{CFG_W{1'b0}}, i_num} >= w_sh);
    always_comb begin
        n_num = i_num;
        n_quo = i_quo;
        if (w_ge) begin
            n_num = i_num - w_sh[IDX_W-1:0];
            n_quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_dsr <= i_dsr;
        end
    end

    assign o_vld = r_vld;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_dsr = r_dsr;
endmodule

// ===== rtl/core/gniu_div_chain.sv =====
// gniu_div_chain: row of division cells, quotient bits high to low, with
// the item context traveling alongside. Depends on gniu_pkg, gniu_div_cell.
module gniu_div_chain #(
    parameter int unsigned NB = gniu_pkg::IDX_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [gniu_pkg::IDX_W-1:0] i_num,
    input  logic [gniu_pkg::CFG_W-1:0] i_dsr,
    input  gniu_pkg::t_ctx             i_ctx,
    output logic                       o_vld,
    output logic [gniu_pkg::IDX_W-1:0] o_quo,
    output logic [gniu_pkg::IDX_W-1:0] o_rem,
    output gniu_pkg::t_ctx             o_ctx
);
    import gniu_pkg::*;

    logic             w_vld [NB+1];
    logic [IDX_W-1:0] w_num [NB+1];
    logic [IDX_W-1:0] w_quo [NB+1];
    logic [CFG_W-1:0] w_dsr [NB+1];
    t_ctx             r_ctx [NB];

    assign w_vld[0] = i_vld;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_dsr[0] = i_dsr;

    for (genvar g = 0; g < NB; g++) begin : g_cell
        gniu_div_cell #(.BIT(NB-1-g)) u_cell (
            .i_clk, .i_rst_n, .i_en,
            .i_vld(w_vld[g]), .i_num(w_num[g]), .i_quo(w_quo[g]), .i_dsr(w_dsr[g]),
            .o_vld(w_vld[g+1]), .o_num(w_num[g+1]), .o_quo(w_quo[g+1]),
            .o_dsr(w_dsr[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[g] <= (g == 0) ? i_ctx : r_ctx[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign o_vld = w_vld[NB];
    assign o_quo = w_quo[NB];
    assign o_rem = w_num[NB];
    assign o_ctx = r_ctx[NB-1];
endmodule

// ===== rtl/core/grid_node_index_unit_core.sv =====
// grid_node_index_unit_core: top level of the grid node index unit.
// Depends on gniu_pkg, gniu_div_chain (two chains of gniu_div_cell).
//
//  channel  | dir | handshake          | payload
//  s_axis   | in  | tvalid/tready      | tdata: mode, part, position, col_i, row_j, layer_k
//  m_axis   | out | tvalid/tready      | tdata: node_index, out_i, out_j, out_k, valid_res
//  cfg      | in  | i_cfg_valid/o_cfg_ready | index, 11-bit data
//
// One item per cycle sustained unless the output stalls. The pipe is two chains of
// 30 division cells (one quotient bit per cell), one register stage for the
// first products, then the second products and selection feed the output
// register. Decompose divides position by sx then by sy;
// face modes use the first chain with divisor sy or sx.
// The whole pipe advances only when the output register is free or taken,
// so a stall freezes every cell; tready is that enable.
// Reset (synchronous, active low) clears valid bits and sets sizes to 1;
// both readies are low while reset is held.
module grid_node_index_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [2:0] mode, [5:3] part, [35:6] position, [45:36] col_i,
    //        [55:46] row_j, [65:56] layer_k, [71:66] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [29:0] node_index, [39:30] out_i, [49:40] out_j, [59:50] out_k,
    //        [60] valid_res, [63:61] zero
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import gniu_pkg::*;

    logic [CFG_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [CFG_W-1:0] w_sx, w_sy, w_sz;
    logic             w_en;

    function automatic logic [CFG_W-1:0] sat(input logic [CFG_W-1:0] v);
        if (v == '0) return CFG_W'(1);
        if (32'(v) > MAX_SIDE_DEF) return CFG_W'(MAX_SIDE_DEF);
        return v;
    endfunction

    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= CFG_W'(1);
            r_size_y <= CFG_W'(1);
            r_size_z <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign w_sx = sat(r_size_x);
    assign w_sy = sat(r_size_y);
    assign w_sz = sat(r_size_z);

    // Pipe enable: advance when output slot is empty or being taken.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;

    t_ctx w_ctx0;
    always_comb begin
        w_ctx0.mode = s_axis_tdata[2:0];
        w_ctx0.part = s_axis_tdata[5:3];
        w_ctx0.pos  = s_axis_tdata[35:6];
        w_ctx0.ci   = s_axis_tdata[45:36];
        w_ctx0.rj   = s_axis_tdata[55:46];
        w_ctx0.lk   = s_axis_tdata[65:56];
        w_ctx0.sx   = w_sx;
        w_ctx0.sy   = w_sy;
        w_ctx0.sz   = w_sz;
    end

    // First division: face right/left by sy, otherwise by sx.
    logic [CFG_W-1:0] w_d1;
    assign w_d1 = (w_ctx0.mode == MODE_FACE &&
                   (w_ctx0.part == FACE_RIGHT || w_ctx0.part == FACE_LEFT)) ? w_sy : w_sx;

    logic             w_v1;
    logic [IDX_W-1:0] w_q1, w_r1;
    t_ctx             w_c1;
    gniu_div_chain u_div1 (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_vld(s_axis_tvalid && s_axis_tready), .i_num(w_ctx0.pos), .i_dsr(w_d1),
        .i_ctx(w_ctx0),
        .o_vld(w_v1), .o_quo(w_q1), .o_rem(w_r1), .o_ctx(w_c1)
    );

    // Second division: q1 / sy (decompose); r1 carried in the ci field.
    t_ctx w_ctx1;
    always_comb begin
        w_ctx1      = w_c1;
        w_ctx1.pos  = w_c1.pos;
        // stash r1 low bits needed by decompose and face modes
        w_ctx1.ci   = (w_c1.mode == MODE_COMPOSE) ? w_c1.ci : w_r1[CRD_W-1:0];
    end
    logic [IDX_W-1:0] r_q1 [IDX_W];
    // q1 must travel too for face modes: a shift line beside chain 2.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q1[0] <= w_q1;
            for (int s = 1; s < IDX_W; s++) r_q1[s] <= r_q1[s-1];
        end
    end

    logic             w_v2;
    logic [IDX_W-1:0] w_q2, w_r2;
    t_ctx             w_c2;
    gniu_div_chain u_div2 (
        .i_clk, .i_rst_n, .i_en(w_en),
        .i_vld(w_v1), .i_num(w_q1), .i_dsr(w_c1.sy), .i_ctx(w_ctx1),
        .o_vld(w_v2), .o_quo(w_q2), .o_rem(w_r2), .o_ctx(w_c2)
    );

    // Multiply stage: layer, face-area, and per-mode products.
    logic             r_v3;
    t_ctx             r_c3;
    logic [IDX_W-1:0] r_q1b, r_q2b, r_r2b;
    logic [21:0]      r_layer, r_fyz, r_fxz;
    logic [31:0]      r_m_lk, r_m_rj;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_en) r_v3 <= w_v2;
        if (w_en) begin
            r_c3    <= w_c2;
            r_q1b   <= r_q1[IDX_W-1];
            r_q2b   <= w_q2;
            r_r2b   <= w_r2;
            r_layer <= 22'(w_c2.sx * w_c2.sy);
            r_fyz   <= 22'(w_c2.sy * w_c2.sz);
            r_fxz   <= 22'(w_c2.sx * w_c2.sz);
            r_m_lk  <= 32'({w_c2.lk} * w_c2.sy);
            r_m_rj  <= 32'(w_c2.rj);
        end
    end

    // Second multiply stage and final selection.
    logic [41:0] w_total, w_comp, w_face_q, w_face_r;
    logic [41:0] w_idx;
    logic        w_val;
    logic [CRD_W-1:0] w_oi, w_oj, w_ok;
    logic [41:0] w_pos;
    always_comb begin
        w_pos   = 42'(r_c3.pos);
        w_total = 42'(r_layer) * 42'(r_c3.sz);
        // lk*layer + rj*sx + ci = (lk*sy + rj)*sx + ci
        w_comp  = 42'(r_m_lk + r_m_rj) * 42'(r_c3.sx) + 42'(r_c3.ci);
        w_face_q = 42'(r_q1b) * 42'(r_layer);
        w_face_r = 42'(r_c3.ci) * 42'(r_c3.sx);
        w_idx = '0; w_val = 1'b0; w_oi = '0; w_oj = '0; w_ok = '0;
        case (r_c3.mode)
            MODE_COMPOSE: begin
                w_idx = w_comp;
                w_val = w_comp < w_total;
            end
            MODE_DECOMPOSE: begin
                w_val = w_pos < w_total;
                w_idx = w_pos;
                w_ok  = CRD_W'(r_q2b);
                w_oj  = CRD_W'(r_r2b);
                w_oi  = r_c3.ci;
            end
            MODE_FACE: begin
                case (r_c3.part)
                    FACE_BOTTOM: begin w_val = w_pos < 42'(r_layer); w_idx = w_pos; end
                    FACE_TOP: begin
                        w_val = w_pos < 42'(r_layer);
                        w_idx = w_total - 42'(r_layer) + w_pos;
                    end
                    FACE_RIGHT: begin
                        w_val = w_pos < 42'(r_fyz);
                        w_idx = w_face_q + w_face_r + 42'(r_c3.sx) - 42'd1;
                    end
                    FACE_LEFT: begin
                        w_val = w_pos < 42'(r_fyz);
                        w_idx = w_face_q + w_face_r;
                    end
                    FACE_BACK: begin
                        w_val = w_pos < 42'(r_fxz);
                        w_idx = w_face_q + 42'(r_layer) - 42'(r_c3.sx) + 42'(r_c3.ci);
                    end
                    FACE_FRONT: begin
                        w_val = w_pos < 42'(r_fxz);
                        w_idx = w_face_q + 42'(r_c3.ci);
                    end
                    default: ;
                endcase
            end
            MODE_SIDE: begin
                case (r_c3.part)
                    SIDE_BOTTOM: begin w_val = w_pos < 42'(r_c3.sx); w_idx = w_pos; end
                    SIDE_RIGHT: begin
                        w_val = w_pos < 42'(r_c3.sy);
                        w_idx = 42'(r_c3.sx) * (w_pos + 42'd1) - 42'd1;
                    end
                    SIDE_TOP: begin
                        w_val = w_pos < 42'(r_c3.sx);
                        w_idx = 42'(r_layer) - (w_pos + 42'd1);
                    end
                    SIDE_LEFT: begin
                        w_val = w_pos < 42'(r_c3.sy);
                        w_idx = 42'(r_layer) - (w_pos + 42'd1) * 42'(r_c3.sx);
                    end
                    default: ;
                endcase
            end
            MODE_CORNER: begin
                w_val = 1'b1;
                case (r_c3.part[1:0])
                    2'd0: w_idx = '0;
                    2'd1: w_idx = 42'(r_c3.sx) - 42'd1;
                    2'd2: w_idx = 42'(r_layer) - 42'd1;
                    default: w_idx = 42'(r_layer) - 42'(r_c3.sx);
                endcase
                if (r_c3.part[2]) w_idx = w_idx + w_total - 42'(r_layer);
            end
            default: ;
        endcase
        if (!w_val) begin
            w_idx = '0; w_oi = '0; w_oj = '0; w_ok = '0;
        end
    end

    logic r_ov;
    logic [63:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r_v3;
        if (w_en) r_od <= {3'b000, w_val, w_ok, w_oj, w_oi, w_idx[IDX_W-1:0]};
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
endmodule

// ===== rtl/core/gniu_checker.sv =====
// gniu_checker: port-level checks for grid_node_index_unit_core, bound in.
// Depends on the top-level port list only.
module gniu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[60] |-> m_axis_tdata[59:0] == '0)
        else $error("invalid result not zeroed");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind grid_node_index_unit_core gniu_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
